/* hw/rtl/sorted_set_union_merge_defines.svh */
// ----------------------------------------------------------------------------
// Sorted set union merge - assertion macros
// Shared assertion forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_UNION_MERGE_DEFINES_SVH
`define SORTED_SET_UNION_MERGE_DEFINES_SVH

// same-cycle implication
`define SSUM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSUM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ssum_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - package
// Payload types, status and command codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ssum_pkg;

    localparam int VALUE_W = 32;
    localparam int ID_W    = 2;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [ID_W-1:0]           t_list_id;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef enum logic [1:0] {
        STAT_ELEM  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_DECIDE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/ssum_in_if.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - command channel
// Valid/ready channel carrying load and emit commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssum_in_if;
    import ssum_pkg::*;

    logic     valid;
    logic     ready;
    logic     command;
    t_list_id list_id;
    t_value   value;

    modport source (output valid, output command, output list_id, output value,
                    input ready);
    modport sink   (input valid, input command, input list_id, input value,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/ssum_out_if.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - result channel
// Valid/ready channel carrying union elements and status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssum_out_if;
    import ssum_pkg::*;

    logic    valid;
    logic    ready;
    t_value  out_value;
    logic    last;
    t_status status;

    modport source (output valid, output out_value, output last, output status,
                    input ready);
    modport sink   (input valid, input out_value, input last, input status,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/sorted_set_union_merge.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - top level
// Stores LISTS ascending lists in one memory and emits their duplicate-free
// ascending union by repeated minimum search over the list heads.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | transaction
//  i_in     | in  | command, list_id, value        | load or emit command
//  o_out    | out | out_value, last, status        | one result
//
//  An emit scans the heads one list at a time per head minimum found,
//  repeats included, and once more to close the run, through the single
//  shared compare unit and the list memory, read one head at a time.
//  Reset clears fill counts, heads, sequencer and output stage; the list
//  memory keeps its contents and needs no clearing pass.
//  A stalled result stage holds the merge; i_in.ready is low during an emit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_set_union_merge_defines.svh"

module sorted_set_union_merge #(
    parameter int LISTS      = 4,
    parameter int LIST_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssum_in_if.sink    i_in,
    ssum_out_if.source o_out
);
    import ssum_pkg::*;

    localparam int DEPTH = LISTS * LIST_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(LISTS);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam logic [LW-1:0] LAST_IDX = LW'(LISTS - 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_fc [LISTS];
    logic [CW-1:0] n_fc [LISTS];
    logic [CW-1:0] r_rp [LISTS];
    logic [CW-1:0] n_rp [LISTS];
    logic [LW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    t_value        r_min, n_min;
    logic [LISTS-1:0] r_mask, n_mask;
    logic          r_lv, n_lv;
    t_value        r_lval, n_lval;

    t_value        r_mem [DEPTH];
    t_value        r_rd;

    logic          r_ov;
    t_value        r_out_val;
    logic          r_out_last;
    t_status       r_out_stat;

    logic          slot_free;
    logic          in_ready;
    logic          emit_new;
    logic [LW-1:0] id_l;
    logic          id_bad;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          out_load;
    t_value        out_val;
    logic          out_last;
    t_status       out_stat;

    assign slot_free = !r_ov || o_out.ready;
    assign in_ready  = (r_state == ST_IDLE) && slot_free;
    assign id_l      = LW'(i_in.list_id);
    assign id_bad    = int'(i_in.list_id) >= LISTS;
    assign emit_new  = !r_lv || (r_min > r_lval);
    assign wr_addr   = AW'(AW'(id_l) * AW'(LIST_DEPTH)) + AW'(r_fc[id_l]);
    assign rd_addr   = AW'(AW'(r_idx) * AW'(LIST_DEPTH)) + AW'(r_rp[r_idx]);

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_ov;
    assign o_out.out_value = r_out_val;
    assign o_out.last      = r_out_last;
    assign o_out.status    = r_out_stat;

    always_comb begin
        n_state  = r_state;
        n_fc     = r_fc;
        n_rp     = r_rp;
        n_idx    = r_idx;
        n_found  = r_found;
        n_min    = r_min;
        n_mask   = r_mask;
        n_lv     = r_lv;
        n_lval   = r_lval;
        mem_we   = 1'b0;
        out_load = 1'b0;
        out_val  = '0;
        out_last = 1'b0;
        out_stat = STAT_ELEM;
        unique case (r_state)
            ST_IDLE: begin
                if (in_ready && i_in.valid) begin
                    if (i_in.command == CMD_EMIT) begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_mask  = '0;
                    end else if (id_bad || (r_fc[id_l] >= CW'(LIST_DEPTH))) begin
                        out_load = 1'b1;
                        out_val  = i_in.value;
                        out_last = 1'b1;
                        out_stat = STAT_FULL;
                    end else begin
                        mem_we      = 1'b1;
                        n_fc[id_l]  = r_fc[id_l] + CW'(1);
                    end
                end
            end
            ST_SCAN: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_rp[r_idx] < r_fc[r_idx]) begin
                    if (!r_found || (r_rd < r_min)) begin
                        n_min   = r_rd;
                        n_found = 1'b1;
                        n_mask  = LISTS'(1) << r_idx;
                    end else if (r_rd == r_min) begin
                        n_mask = r_mask | (LISTS'(1) << r_idx);
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_idx   = r_idx + LW'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_DECIDE: begin
                if (!r_found) begin
                    n_state = ST_FINISH;
                end else if (!(emit_new && r_lv && !slot_free)) begin
                    for (int l = 0; l < LISTS; l++) begin
                        if (r_mask[l]) begin
                            n_rp[l] = r_rp[l] + CW'(1);
                        end
                    end
                    if (emit_new) begin
                        out_load = r_lv;
                        out_val  = r_lval;
                        n_lv     = 1'b1;
                        n_lval   = r_min;
                    end
                    n_found = 1'b0;
                    n_mask  = '0;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_val  = r_lv ? r_lval : '0;
                    out_last = 1'b1;
                    out_stat = r_lv ? STAT_ELEM : STAT_EMPTY;
                    for (int l = 0; l < LISTS; l++) begin
                        n_fc[l] = '0;
                        n_rp[l] = '0;
                    end
                    n_lv    = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int l = 0; l < LISTS; l++) begin
                r_fc[l] <= '0;
                r_rp[l] <= '0;
            end
            r_idx   <= '0;
            r_found <= 1'b0;
            r_mask  <= '0;
            r_lv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fc    <= n_fc;
            r_rp    <= n_rp;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_mask  <= n_mask;
            r_lv    <= n_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min  <= n_min;
        r_lval <= n_lval;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_in.value;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_val  <= out_val;
            r_out_last <= out_last;
            r_out_stat <= out_stat;
        end
    end

    `SSUM_ASSERT_NOW(a_status_last, r_ov && (r_out_stat != STAT_ELEM), r_out_last, "status result without last")
    `SSUM_ASSERT_NOW(a_idle_no_pending, r_state == ST_IDLE, !r_lv, "pending element left after run")
    `SSUM_ASSERT_NEXT(a_finish_closes, (r_state == ST_FINISH) && slot_free, (r_state == ST_IDLE) && r_ov && r_out_last, "run closed without last result")

    for (genvar g = 0; g < LISTS; g++) begin : g_head_chk
        `SSUM_ASSERT_NOW(a_head_in_range, 1'b1, r_rp[g] <= r_fc[g], "list head beyond fill count")
    end

endmodule

`default_nettype wire

/* verif/union_check_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - result checker
// Tracks the stored lists from accepted commands, forms the expected
// duplicate-free ascending union on each emit and checks every result.
// ----------------------------------------------------------------------------
package union_check_pkg;
    import ssum_pkg::*;

    localparam int LIST_COUNT = 4;
    localparam int LIST_DEPTH = 16;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_value  value;
        logic    last;
        t_status status;
    } t_union_result;

    class union_checker;
        t_value        list_mem [LIST_COUNT][LIST_DEPTH];
        int unsigned   list_fill [LIST_COUNT];
        t_union_result pending [$];
        int            errors;

        function new();
            errors = 0;
            foreach (list_fill[l]) list_fill[l] = 0;
        endfunction

        function int pending_count();
            return pending.size();
        endfunction

        function void add_expected(t_value val, logic last, t_status st);
            t_union_result item;
            item.value  = val;
            item.last   = last;
            item.status = st;
            pending.insert(pending.size(), item);
        endfunction

        function void note_command(logic cmd, t_list_id id, t_value val);
            if (cmd == CMD_EMIT) begin
                merge_union();
            end else if (id >= LIST_COUNT || list_fill[id] >= LIST_DEPTH) begin
                add_expected(val, 1'b1, STAT_FULL);
            end else begin
                list_mem[id][list_fill[id]] = val;
                list_fill[id]++;
            end
        endfunction

        // pick the minimum head, advance every head equal to it, drop non-ascending
        function void merge_union();
            int unsigned head [LIST_COUNT];
            int          produced;
            logic        found;
            logic        have_prev;
            t_value      prev;
            t_value      low;
            produced  = 0;
            have_prev = 1'b0;
            prev      = '0;
            low       = '0;
            foreach (head[l]) head[l] = 0;
            do begin
                found = 1'b0;
                for (int l = 0; l < LIST_COUNT; l++) begin
                    if (head[l] < list_fill[l] && (!found || list_mem[l][head[l]] < low)) begin
                        low   = list_mem[l][head[l]];
                        found = 1'b1;
                    end
                end
                if (found) begin
                    for (int l = 0; l < LIST_COUNT; l++) begin
                        if (head[l] < list_fill[l] && list_mem[l][head[l]] == low) begin
                            head[l]++;
                        end
                    end
                    if (!have_prev || low > prev) begin
                        add_expected(low, 1'b0, STAT_ELEM);
                        produced++;
                        have_prev = 1'b1;
                        prev      = low;
                    end
                end
            end while (found);
            if (produced == 0) begin
                add_expected('0, 1'b1, STAT_EMPTY);
            end else begin
                pending[pending.size()-1].last = 1'b1;
            end
            foreach (list_fill[l]) list_fill[l] = 0;
        endfunction

        function void check_result(t_value val, logic last, t_status st);
            t_union_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("unexpected result: value %0d last %0b status %0d",
                             val, last, st);
                end
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (want.value !== val || want.last !== last || want.status !== st) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("mismatch: expected value %0d last %0b status %0d,",
                             want.value, want.last, want.status,
                             " got value %0d last %0b status %0d", val, last, st);
                end
            end
        endfunction
    endclass

endpackage

/* verif/sorted_set_union_merge_test.sv */
// ----------------------------------------------------------------------------
// Sorted set union merge - testbench
// Loads sorted, repeated and unsorted lists, overfills them and emits their
// union, with random gaps on the command side and random stalls on the
// result side; every result transaction is checked against a local model.
// ----------------------------------------------------------------------------
module sorted_set_union_merge_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssum_pkg::*;
    import union_check_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk;
    logic i_rst_n;
    int   items_sent = 0;

    union_checker board = new();

    ssum_in_if  in_ch();
    ssum_out_if out_ch();

    sorted_set_union_merge #(
        .LISTS     (LIST_COUNT),
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic cmd, input t_list_id id, input t_value val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.list_id <= id;
        in_ch.value   <= val;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_command(cmd, id, val);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        t_value v;
        send_item(CMD_EMIT, 2'd0, 32'sd0);
        send_item(CMD_LOAD, 2'd0, 32'sd0);
        send_item(CMD_LOAD, 2'd0, 32'sd3);
        send_item(CMD_LOAD, 2'd2, 32'sd0);
        send_item(CMD_LOAD, 2'd2, 32'sd0);
        send_item(CMD_LOAD, 2'd3, 32'sd5);
        send_item(CMD_LOAD, 2'd3, 32'sd3);
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (k == 0) v = 32'h8000_0000;
            else if (k == LIST_DEPTH - 1) v = 32'h7fff_ffff;
            else v = (k - 7) * 3;
            send_item(CMD_LOAD, 2'd1, v);
        end
        send_item(CMD_LOAD, 2'd1, 32'h5a5a_a5a5);
        send_item(CMD_EMIT, 2'd3, 32'hffff_ffff);
    endtask

    // mostly ascending lists with steps up to 2, 50 or 2^20, some rounds fully random
    task automatic run_round();
        t_value   prev [LIST_COUNT];
        logic     started [LIST_COUNT];
        logic     wild;
        int       n_loads;
        int       r;
        int       spread;
        t_value   base;
        t_value   v;
        t_list_id l;
        wild = ($urandom_range(0, 9) < 2);
        r = $urandom_range(0, 9);
        if (r < 7) n_loads = $urandom_range(0, 12);
        else if (r < 9) n_loads = $urandom_range(13, 40);
        else n_loads = $urandom_range(41, 72);
        r = $urandom_range(0, 2);
        spread = (r == 0) ? 2 : (r == 1) ? 50 : (1 << 20);
        base = $urandom;
        foreach (started[i]) started[i] = 1'b0;
        repeat (n_loads) begin
            l = t_list_id'($urandom_range(0, LIST_COUNT - 1));
            if (wild) v = $urandom;
            else if (!started[l]) v = base + $urandom_range(0, spread);
            else v = prev[l] + $urandom_range(0, spread);
            prev[l]    = v;
            started[l] = 1'b1;
            send_item(CMD_LOAD, l, v);
        end
        send_item(CMD_EMIT, t_list_id'($urandom_range(0, LIST_COUNT - 1)), $urandom);
    endtask

    initial begin
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            board.check_result(out_ch.out_value, out_ch.last, out_ch.status);
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.list_id = '0;
        in_ch.value   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        while (items_sent < ITEM_TARGET) run_round();
        in_ch.valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ssum_pkg.sv
hw/rtl/ssum_in_if.sv
hw/rtl/ssum_out_if.sv
hw/rtl/sorted_set_union_merge.sv
verif/union_check_pkg.sv
verif/sorted_set_union_merge_test.sv
